@@ rtl/assert_macros.svh @@
// Assertion macros of the port-level checker of the escape-time pixel block.
// Needs nothing else; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while the reset is held (active low).
`define MEP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Concurrent assertion that is checked in every cycle, reset included.
`define MEP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/mep_pkg.sv @@
// Shared constants, payload types and helper functions of the escape-time pixel block.
// Depends on nothing; every module, interface and testbench file imports it.
package mep_pkg;

    // Fixed-point format of the coordinates: signed Q6.26.
    localparam int COORD_W   = 32;
    localparam int FRAC_W    = COORD_W - 6;
    localparam int PROD_W    = 2 * COORD_W;
    // Width that holds every sum that is saturated back to a coordinate.
    localparam int SAT_W     = PROD_W + 2;

    // Grid and iteration counter widths.
    localparam int GRID_SIZE = 4096;
    localparam int IDX_W     = $clog2(GRID_SIZE);
    localparam int ITER_W    = 10;
    localparam int CNT_W     = ITER_W + 1;

    // Colour arithmetic.
    localparam int            COLOR_W    = 8;
    localparam logic [COLOR_W-1:0] COLOR_FULL = 8'd255;

    // |z|^2 escape threshold: 4.0 at double-width fraction.
    localparam logic [PROD_W-1:0] ESCAPE_LIMIT = PROD_W'(1) << (2 * FRAC_W + 2);

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Configuration register indexes.
    localparam int             CFG_IDX_W      = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_START    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_START    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE = 3'd5;

    // Reset values of the configuration registers.
    localparam logic signed [COORD_W-1:0] X_START_RST = -32'sd134217728;
    localparam logic signed [COORD_W-1:0] Y_START_RST = -32'sd100663296;
    localparam logic signed [COORD_W-1:0] X_STEP_RST  = 32'sd196608;
    localparam logic signed [COORD_W-1:0] Y_STEP_RST  = 32'sd196608;
    localparam logic [ITER_W-1:0]         MAX_ITER_RST = 10'd255;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [SAT_W-1:0]   t_wide;

    // Input request: one grid pixel.
    typedef struct packed {
        logic [IDX_W-1:0] column;
        logic [IDX_W-1:0] row;
    } t_pix_in;

    // Result request: one coloured pixel.
    typedef struct packed {
        logic [IDX_W-1:0]   pixel_column;
        logic [IDX_W-1:0]   pixel_row;
        logic [CNT_W-1:0]   iterations;
        logic               inside_res;
        logic               draw_pixel;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_pix_out;

    // Configuration register file as seen by the front and the back.
    typedef struct packed {
        t_coord              x_start;
        t_coord              y_start;
        t_coord              x_step;
        t_coord              y_step;
        logic [ITER_W-1:0]   max_iter;
        logic                color_mode;
    } t_cfg;

    // A classified pixel waiting in the queue: indexes and point c.
    typedef struct packed {
        logic [IDX_W-1:0] column;
        logic [IDX_W-1:0] row;
        t_coord           cx;
        t_coord           cy;
    } t_job;

    // Saturate a wide signed value to the coordinate range.
    function automatic t_coord sat_coord(input t_wide v);
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &v[SAT_W-1:COORD_W-1];
        hi_zeros = ~|v[SAT_W-1:COORD_W-1];
        if (hi_ones || hi_zeros) begin
            sat_coord = v[COORD_W-1:0];
        end else if (v[SAT_W-1]) begin
            sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

endpackage

@@ rtl/mep_stream_if.sv @@
// Valid/ready stream interface that carries one request type per channel.
// Depends on mep_pkg for the default payload type.
interface mep_stream_if import mep_pkg::*; #(
    parameter type t_data = t_pix_in
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/mep_front.sv @@
// Front part: accepts pixel requests and maps the grid indexes to the point c.
// Depends on mep_pkg and mep_stream_if; feeds mep_queue.
module mep_front import mep_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    mep_stream_if.sink   i_pix,
    input  logic         i_q_full,
    output logic         o_push,
    output t_job         o_job
);
    localparam int PX_W = IDX_W + 1 + COORD_W;

    logic                   r_s1_vld;
    logic [IDX_W-1:0]       r_col;
    logic [IDX_W-1:0]       r_row;
    logic signed [PX_W-1:0] r_px;
    logic signed [PX_W-1:0] r_py;
    logic signed [PX_W-1:0] n_px;
    logic signed [PX_W-1:0] n_py;
    logic                   take;

    // The product stage empties into the queue whenever there is room.
    assign o_push      = r_s1_vld && !i_q_full;
    assign i_pix.ready = !r_s1_vld || !i_q_full;
    assign take        = i_pix.valid && i_pix.ready;

    // Index times step; the index enters as an unsigned value and the product is exact.
    always_comb begin
        n_px = $signed({1'b0, i_pix.data.column}) * i_cfg.x_step;
        n_py = $signed({1'b0, i_pix.data.row}) * i_cfg.y_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (take) begin
            r_s1_vld <= 1'b1;
        end else if (o_push) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_col <= i_pix.data.column;
            r_row <= i_pix.data.row;
            r_px  <= n_px;
            r_py  <= n_py;
        end
    end

    // Add the window origin and saturate to Q6.26.
    always_comb begin
        o_job.column = r_col;
        o_job.row    = r_row;
        o_job.cx     = sat_coord(SAT_W'(r_px) + SAT_W'(i_cfg.x_start));
        o_job.cy     = sat_coord(SAT_W'(r_py) + SAT_W'(i_cfg.y_start));
    end

endmodule

@@ rtl/mep_queue.sv @@
// Short queue of classified pixels between the front and the back.
// Depends on mep_pkg for the entry type.
module mep_queue import mep_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_avail,
    output t_job o_job
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] FULL = CNT_QW'(DEPTH);

    t_job              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_count;

    assign o_full  = (r_count == FULL);
    assign o_avail = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_QW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_QW'(1);
            end
        end
    end

endmodule

@@ rtl/mep_back.sv @@
// Back part: runs the escape-time loop, the colour step divider and the result register.
// Depends on mep_pkg and mep_stream_if; fed by mep_queue.
module mep_back import mep_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  logic         i_q_avail,
    input  t_job         i_job,
    output logic         o_pop,
    mep_stream_if.source o_pix
);
    localparam int ST_W   = 3;
    localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
    localparam logic [ST_W-1:0] ST_MUL  = 3'd1;
    localparam logic [ST_W-1:0] ST_UPD  = 3'd2;
    localparam logic [ST_W-1:0] ST_DIV  = 3'd3;
    localparam logic [ST_W-1:0] ST_OUT  = 3'd4;
    localparam int REM_W  = ITER_W + 1;
    localparam int DCNT_W = $clog2(COLOR_W);
    localparam int GP_W   = COLOR_W + CNT_W;

    logic [ST_W-1:0]    r_state;
    logic [IDX_W-1:0]   r_col;
    logic [IDX_W-1:0]   r_row;
    t_coord             r_cx;
    t_coord             r_cy;
    t_coord             r_zx;
    t_coord             r_zy;
    logic [PROD_W-1:0]  r_sx;
    logic [PROD_W-1:0]  r_sy;
    logic signed [PROD_W-1:0] r_cross;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_inside;
    logic [REM_W-1:0]   r_rem;
    logic [COLOR_W-1:0] r_dvd;
    logic [COLOR_W-1:0] r_quo;
    logic [DCNT_W-1:0]  r_dcnt;
    logic               r_o_vld;
    t_pix_out           r_o_data;

    logic signed [PROD_W-1:0] sq_x;
    logic signed [PROD_W-1:0] sq_y;
    logic signed [PROD_W-1:0] prod_xy;
    logic [PROD_W-1:0]  mag2;
    logic signed [PROD_W-1:0] diff;
    logic               keep_going;
    logic               inside_now;
    t_coord             n_zx;
    t_coord             n_zy;
    logic [REM_W-1:0]   trial;
    logic [REM_W-1:0]   divisor;
    logic [GP_W-1:0]    green_prod;
    logic [COLOR_W-1:0] shade;
    logic               out_free;
    t_pix_out           n_o_data;

    assign o_pix.valid = r_o_vld;
    assign o_pix.data  = r_o_data;
    assign out_free    = !r_o_vld || o_pix.ready;
    assign o_pop       = (r_state == ST_IDLE) && i_q_avail;

    // Squares and cross product of the current z, registered before use.
    always_comb begin
        sq_x    = r_zx * r_zx;
        sq_y    = r_zy * r_zy;
        prod_xy = r_zx * r_zy;
    end

    // Escape test and the next z from the registered products.
    always_comb begin
        mag2       = r_sx + r_sy;
        keep_going = (r_cnt <= CNT_W'(i_cfg.max_iter)) && (mag2 <= ESCAPE_LIMIT);
        inside_now = (r_cnt >= CNT_W'(i_cfg.max_iter));
        diff       = $signed(r_sx - r_sy);
        n_zy       = sat_coord(SAT_W'(r_cross >>> (FRAC_W - 1)) + SAT_W'(r_cy));
        n_zx       = sat_coord(SAT_W'(diff >>> FRAC_W) + SAT_W'(r_cx));
    end

    // One restoring division step of 255 by the iteration limit.
    always_comb begin
        divisor = REM_W'(i_cfg.max_iter);
        trial   = {r_rem[REM_W-2:0], r_dvd[COLOR_W-1]};
    end

    // Colour of the finished pixel.
    always_comb begin
        green_prod            = GP_W'(r_quo) * GP_W'(r_cnt);
        shade                 = COLOR_FULL - green_prod[COLOR_W-1:0];
        n_o_data.pixel_column = r_col;
        n_o_data.pixel_row    = r_row;
        n_o_data.iterations   = r_cnt;
        n_o_data.inside_res   = r_inside;
        if (r_inside) begin
            n_o_data.draw_pixel = 1'b1;
            n_o_data.red        = '0;
            n_o_data.green      = '0;
            n_o_data.blue       = '0;
        end else if (i_cfg.color_mode) begin
            n_o_data.draw_pixel = 1'b1;
            n_o_data.red        = COLOR_FULL;
            n_o_data.green      = shade;
            n_o_data.blue       = shade;
        end else begin
            n_o_data.draw_pixel = 1'b0;
            n_o_data.red        = '0;
            n_o_data.green      = '0;
            n_o_data.blue       = '0;
        end
    end

    // Sequencer of the back part.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dcnt  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_avail) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    if (keep_going) begin
                        r_state <= ST_MUL;
                    end else if (inside_now || !i_cfg.color_mode) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_dcnt  <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_dcnt <= r_dcnt + DCNT_W'(1);
                    if (r_dcnt == DCNT_W'(COLOR_W - 1)) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Working registers of the loop and the divider.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_col <= i_job.column;
                r_row <= i_job.row;
                r_cx  <= i_job.cx;
                r_cy  <= i_job.cy;
                r_zx  <= i_job.cx;
                r_zy  <= i_job.cy;
                r_cnt <= '0;
            end
            ST_MUL: begin
                r_sx    <= $unsigned(sq_x);
                r_sy    <= $unsigned(sq_y);
                r_cross <= prod_xy;
            end
            ST_UPD: begin
                r_inside <= inside_now;
                r_rem    <= '0;
                r_dvd    <= COLOR_FULL;
                r_quo    <= '0;
                if (keep_going) begin
                    r_zx  <= n_zx;
                    r_zy  <= n_zy;
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            ST_DIV: begin
                r_dvd <= {r_dvd[COLOR_W-2:0], 1'b0};
                if (trial >= divisor) begin
                    r_rem <= trial - divisor;
                    r_quo <= {r_quo[COLOR_W-2:0], 1'b1};
                end else begin
                    r_rem <= trial;
                    r_quo <= {r_quo[COLOR_W-2:0], 1'b0};
                end
            end
            default: begin
            end
        endcase
    end

    // Result register: holds a finished pixel until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if ((r_state == ST_OUT) && out_free) begin
            r_o_vld <= 1'b1;
        end else if (o_pix.ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && out_free) begin
            r_o_data <= n_o_data;
        end
    end

endmodule

@@ rtl/mandelbrot_escape_pixel_top.sv @@
// Top level of the escape-time pixel block: configuration registers, front, queue, back.
// Depends on mep_pkg, mep_stream_if, mep_front, mep_queue and mep_back.
//
//  channel   direction  handshake             payload
//  i_pix     in         i_pix.valid/ready     column, row
//  o_pix     out        o_pix.valid/ready     pixel fields and colour
//  i_cfg_*   in         i_cfg_we, no wait     register index and data
//
// The front registers each request and pushes its point c once the queue has room.
// The back loads the job, then runs each escape test as a multiply state (the three
// 32 by 32 products) and an update state; coloured outside pixels then pass through
// the colour divider, and every pixel ends in the state that loads the result register.
// Reset is synchronous and active low; it empties the queue and the result register and
// restores the configuration. A stalled result holds the back while the front and the
// queue go on accepting requests until the queue is full.
module mandelbrot_escape_pixel_top import mep_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COORD_W-1:0]   i_cfg_data,
    mep_stream_if.sink           i_pix,
    mep_stream_if.source         o_pix
);
    t_cfg r_cfg;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_avail;
    t_job front_job;
    t_job queue_job;

    // Configuration register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_start    <= X_START_RST;
            r_cfg.y_start    <= Y_START_RST;
            r_cfg.x_step     <= X_STEP_RST;
            r_cfg.y_step     <= Y_STEP_RST;
            r_cfg.max_iter   <= MAX_ITER_RST;
            r_cfg.color_mode <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_X_START:    r_cfg.x_start    <= $signed(i_cfg_data);
                CFG_Y_START:    r_cfg.y_start    <= $signed(i_cfg_data);
                CFG_X_STEP:     r_cfg.x_step     <= $signed(i_cfg_data);
                CFG_Y_STEP:     r_cfg.y_step     <= $signed(i_cfg_data);
                CFG_MAX_ITER:   r_cfg.max_iter   <= i_cfg_data[ITER_W-1:0];
                CFG_COLOR_MODE: r_cfg.color_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    mep_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_pix    (i_pix),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (front_job)
    );

    mep_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_avail (q_avail),
        .o_job   (queue_job)
    );

    mep_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_avail (q_avail),
        .i_job     (queue_job),
        .o_pop     (q_pop),
        .o_pix     (o_pix)
    );

endmodule

@@ rtl/mep_checker.sv @@
// Port-level checker of the escape-time pixel block and its bind to the top level.
// Depends on mep_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mep_checker import mep_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_out_valid,
    input logic     i_out_ready,
    input t_pix_out i_out_data
);

    // A result that is not taken stays offered.
    `MEP_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result withdrawn while stalled")

    // A pixel inside the set is drawn black.
    `MEP_ASSERT(a_inside_black, i_clk, i_rst_n, i_out_valid && i_out_data.inside_res |-> i_out_data.draw_pixel && (i_out_data.red == '0) && (i_out_data.green == '0) && (i_out_data.blue == '0), "inside pixel not black")

    // A drawn outside pixel has full red and equal green and blue.
    `MEP_ASSERT(a_outside_colour, i_clk, i_rst_n, i_out_valid && i_out_data.draw_pixel && !i_out_data.inside_res |-> (i_out_data.red == COLOR_FULL) && (i_out_data.green == i_out_data.blue), "outside pixel colour malformed")

    // Reset empties the result register.
    `MEP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind mandelbrot_escape_pixel_top mep_checker u_mep_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_data  (o_pix.data)
);

@@ tb/sv/mandelbrot_escape_pixel_checker.sv @@
// Checker of the escape-time pixel block: predicts every pixel result and compares it.
// Depends on mep_pkg; watches the configuration port and both request channels.
module mandelbrot_escape_pixel_checker import mep_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COORD_W-1:0]   i_cfg_data,
    input  logic                 i_req_valid,
    input  logic                 i_req_ready,
    input  t_pix_in              i_req_data,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  t_pix_out             i_res_data,
    output int                   o_failures,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint          COORD_TOP    = (longint'(1) <<< (COORD_W - 1)) - 1;
    localparam longint          COORD_BOTTOM = -COORD_TOP - 1;
    localparam longint unsigned ESCAPE_BOUND = 64'd4 << (2 * FRAC_W);

    // Shadow copy of the configuration registers.
    longint      x_start;
    longint      y_start;
    longint      x_step;
    longint      y_step;
    int unsigned max_iter;
    logic        colour_mode;

    // Predicted pixels, oldest first.
    t_pix_out    expected_pixels[$];
    int          mismatch_count = 0;

    assign o_failures = mismatch_count;
    assign o_pending  = expected_pixels.size();

    function automatic longint clamp_coord(input longint v);
        if (v > COORD_TOP) begin
            return COORD_TOP;
        end
        if (v < COORD_BOTTOM) begin
            return COORD_BOTTOM;
        end
        return v;
    endfunction

    function automatic longint unsigned mag_square(input longint v);
        longint unsigned m;
        if (v < 0) begin
            m = -v;
        end else begin
            m = v;
        end
        return m * m;
    endfunction

    // Escape-time count and colour of one pixel under the current settings.
    function automatic t_pix_out escape_pixel(input t_pix_in px);
        longint          cx;
        longint          cy;
        longint          zx;
        longint          zy;
        longint          cross_prod;
        longint          diff;
        longint unsigned sx;
        longint unsigned sy;
        int unsigned     count;
        int unsigned     shade_step;
        t_pix_out        res;
        cx    = clamp_coord(x_start + longint'(px.column) * x_step);
        cy    = clamp_coord(y_start + longint'(px.row) * y_step);
        zx    = cx;
        zy    = cy;
        sx    = mag_square(zx);
        sy    = mag_square(zy);
        count = 0;
        // Products are exact at double width; the arithmetic shift floors them.
        while (count <= max_iter && sx + sy <= ESCAPE_BOUND) begin
            cross_prod = zx * zy;
            diff       = longint'(sx) - longint'(sy);
            zy         = clamp_coord((cross_prod >>> (FRAC_W - 1)) + cy);
            zx         = clamp_coord((diff >>> FRAC_W) + cx);
            sx         = mag_square(zx);
            sy         = mag_square(zy);
            count++;
        end

        res              = '0;
        res.pixel_column = px.column;
        res.pixel_row    = px.row;
        res.iterations   = CNT_W'(count);
        res.inside_res   = (count >= max_iter);
        // Inside pixels are black; outside ones are shaded only in colour mode.
        if (res.inside_res) begin
            res.draw_pixel = 1'b1;
        end else if (colour_mode) begin
            shade_step     = int'(COLOR_FULL) / max_iter;
            res.draw_pixel = 1'b1;
            res.red        = COLOR_FULL;
            res.green      = COLOR_W'(int'(COLOR_FULL) - shade_step * count);
            res.blue       = res.green;
        end
        return res;
    endfunction

    task automatic report_failure(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want,
                               input t_pix_out want_px);
        if (got != want) begin
            report_failure($sformatf("pixel (%0d,%0d) %s is %0d, expected %0d",
                                     want_px.pixel_column, want_px.pixel_row,
                                     name, got, want));
        end
    endtask

    // Track the settings, predict on each accepted request and compare each result.
    always @(posedge i_clk) begin
        t_pix_out want;
        if (!i_rst_n) begin
            x_start     = X_START_RST;
            y_start     = Y_START_RST;
            x_step      = X_STEP_RST;
            y_step      = Y_STEP_RST;
            max_iter    = MAX_ITER_RST;
            colour_mode = 1'b1;
            expected_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_X_START:    x_start     = longint'(signed'(i_cfg_data));
                    CFG_Y_START:    y_start     = longint'(signed'(i_cfg_data));
                    CFG_X_STEP:     x_step      = longint'(signed'(i_cfg_data));
                    CFG_Y_STEP:     y_step      = longint'(signed'(i_cfg_data));
                    CFG_MAX_ITER:   max_iter    = i_cfg_data[ITER_W-1:0];
                    CFG_COLOR_MODE: colour_mode = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready) begin
                expected_pixels.push_back(escape_pixel(i_req_data));
            end
            if (i_res_valid && i_res_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_failure($sformatf("result for pixel (%0d,%0d) with no request open",
                                             i_res_data.pixel_column, i_res_data.pixel_row));
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("column", i_res_data.pixel_column, want.pixel_column, want);
                    check_field("row", i_res_data.pixel_row, want.pixel_row, want);
                    check_field("iterations", i_res_data.iterations, want.iterations, want);
                    check_field("inside", i_res_data.inside_res, want.inside_res, want);
                    check_field("draw", i_res_data.draw_pixel, want.draw_pixel, want);
                    check_field("red", i_res_data.red, want.red, want);
                    check_field("green", i_res_data.green, want.green, want);
                    check_field("blue", i_res_data.blue, want.blue, want);
                end
            end
        end
    end

endmodule

@@ tb/sv/mandelbrot_escape_pixel_top_tb.sv @@
// Testbench top of the escape-time pixel block: clock, reset, stimulus and verdict.
// Depends on mep_pkg, mep_stream_if, the block's top level and the pixel checker.
module mandelbrot_escape_pixel_top_tb import mep_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 10;
    localparam int QUIET_LIMIT    = 20000;
    localparam int SETTLE_CYCLES  = 2100;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_REQUESTS = 40;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [COORD_W-1:0]   cfg_data;
    int                   send_idle_pct = 0;
    int                   stall_pct     = 0;
    int                   failures;
    int                   pending;
    int                   quiet_cycles  = 0;

    mep_stream_if #(.t_data(t_pix_in))  pix_req_if ();
    mep_stream_if #(.t_data(t_pix_out)) pix_res_if ();

    mandelbrot_escape_pixel_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_req_if),
        .o_pix      (pix_res_if)
    );

    mandelbrot_escape_pixel_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_req_valid (pix_req_if.valid),
        .i_req_ready (pix_req_if.ready),
        .i_req_data  (pix_req_if.data),
        .i_res_valid (pix_res_if.valid),
        .i_res_ready (pix_res_if.ready),
        .i_res_data  (pix_res_if.data),
        .o_failures  (failures),
        .o_pending   (pending)
    );

    // Free-running clock.
    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // Result side: ready is redrawn at every falling edge.
    initial begin
        pix_res_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            pix_res_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: ends the run when neither channel has moved a request for too long.
    always @(posedge i_clk) begin
        if ((pix_req_if.valid && pix_req_if.ready) || (pix_res_if.valid && pix_res_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic logic [COORD_W-1:0] rand_between(input int lo, input int hi);
        return COORD_W'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    // Mostly uniform grid indexes, with the edges of the grid now and then.
    function automatic logic [IDX_W-1:0] rand_index();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5) begin
            return '0;
        end else if (pick < 10) begin
            return '1;
        end
        return IDX_W'($urandom_range(0, GRID_SIZE - 1));
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_pixel(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_req_if.valid       <= 1'b1;
        pix_req_if.data.column <= col;
        pix_req_if.data.row    <= row;
        do begin
            @(posedge i_clk);
        end while (!pix_req_if.ready);
        @(negedge i_clk);
    endtask

    // Hold off new requests until every predicted pixel has come back.
    task automatic wait_drained();
        pix_req_if.valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
    endtask

    // Rewrite every register once the block has nothing in flight.
    task automatic apply_config(input logic [COORD_W-1:0] xs, input logic [COORD_W-1:0] ys,
                                input logic [COORD_W-1:0] xst, input logic [COORD_W-1:0] yst,
                                input logic [ITER_W-1:0] mi, input logic cm);
        wait_drained();
        write_reg(CFG_X_START, xs);
        write_reg(CFG_Y_START, ys);
        write_reg(CFG_X_STEP, xst);
        write_reg(CFG_Y_STEP, yst);
        write_reg(CFG_MAX_ITER, COORD_W'(mi));
        write_reg(CFG_COLOR_MODE, COORD_W'(cm));
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [COORD_W-1:0] xs;
        logic [COORD_W-1:0] ys;
        logic [COORD_W-1:0] xst;
        logic [COORD_W-1:0] yst;
        logic [ITER_W-1:0]  mi;
        logic               cm;
        int unsigned        pick;

        i_rst_n          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= '0;
        cfg_data         <= '0;
        pix_req_if.valid <= 1'b0;
        pix_req_if.data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Settings after reset: grid corners, the centre of the set and a few inner points.
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd683, 12'd512);
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'd600, 12'd700);
        send_pixel(12'd1365, 12'd2730);

        // Black-and-white mode with the smallest useful limit.
        apply_config(X_START_RST, Y_START_RST, X_STEP_RST, Y_STEP_RST, 10'd1, 1'b0);
        send_pixel(12'd683, 12'd512);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);

        // A zero limit turns every pixel black.
        apply_config(X_START_RST, Y_START_RST, X_STEP_RST, Y_STEP_RST, 10'd0, 1'b1);
        send_pixel(12'd683, 12'd512);
        send_pixel(12'd0, 12'd0);

        // Extreme starts and steps drive the point c into saturation.
        apply_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     10'd1023, 1'b1);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd0);

        // Points on the escape circle: c = -2 never leaves it, c = 2 leaves after one step.
        apply_config(32'hF800_0000, 32'h0000_0000, 32'h1000_0000, 32'h0000_0000,
                     10'd1023, 1'b1);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd4095);
        send_pixel(12'd2, 12'd0);

        // Random phases: new window, limit and idling pattern in each.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p % 5 == 0) begin
                xs  = $urandom;
                ys  = $urandom;
                xst = $urandom;
                yst = $urandom;
                mi  = ITER_W'($urandom_range(0, 1023));
            end else begin
                xs   = rand_between(-167772160, 33554432);
                ys   = rand_between(-100663296, 33554432);
                xst  = rand_between(-49152, 49152);
                yst  = rand_between(-49152, 49152);
                pick = $urandom_range(99);
                if (p == 3) begin
                    mi = 10'd1023;
                end else if (p == 7) begin
                    mi = 10'd1;
                end else if (pick < 50) begin
                    mi = ITER_W'($urandom_range(2, 40));
                end else if (pick < 80) begin
                    mi = ITER_W'($urandom_range(41, 255));
                end else begin
                    mi = ITER_W'($urandom_range(256, 700));
                end
            end
            cm = 1'($urandom_range(0, 1));
            apply_config(xs, ys, xst, yst, mi, cm);

            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 58;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 58;
                end
                default: begin
                    send_idle_pct = 13;
                    stall_pct     = 13;
                end
            endcase

            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                send_pixel(rand_index(), rand_index());
            end
        end

        // Let every result come back, then give the block time to show any stray one.
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/mep_pkg.sv
rtl/mep_stream_if.sv
rtl/mep_front.sv
rtl/mep_queue.sv
rtl/mep_back.sv
rtl/mandelbrot_escape_pixel_top.sv
rtl/mep_checker.sv
tb/sv/mandelbrot_escape_pixel_checker.sv
tb/sv/mandelbrot_escape_pixel_top_tb.sv
